### rtl/core/base64_line_wrapped_encoder_top_defines.svh
// ---------------------------------------------------------------------------
// Base64 line-wrapped encoder assertion macros
// Shared assertion forms, clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef BASE64_LINE_WRAPPED_ENCODER_TOP_DEFINES_SVH
`define BASE64_LINE_WRAPPED_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication.
`define B64LW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define B64LW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/b64lw_pkg.sv
// ---------------------------------------------------------------------------
// Base64 line-wrapped encoder package
// Shared job type, character constants and the alphabet lookup.
// ---------------------------------------------------------------------------
package b64lw_pkg;

  localparam logic [7:0] CharNl  = 8'd10;
  localparam logic [7:0] CharPad = 8'd61;

  // Number of output slots one job can fill: leading newline, four
  // characters of a block, trailing newline.
  localparam int unsigned NumSlots = 6;

  typedef struct packed {
    logic       lead_nl;
    logic       has_block;
    logic       pad3;
    logic       pad4;
    logic       tail_nl;
    logic       tail_done;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } job_t;

  typedef logic [NumSlots-1:0] slot_mask_t;

  // Slot 0 is the leading newline, slots 1 to 4 the block, slot 5 the
  // trailing newline.
  function automatic slot_mask_t job_mask(input job_t job);
    job_mask = {job.tail_nl, {4{job.has_block}}, job.lead_nl};
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] wide;
    wide = {2'b00, idx};
    if (idx < 6'd26) begin
      b64_char = 8'd65 + wide;
    end else if (idx < 6'd52) begin
      b64_char = 8'd71 + wide;
    end else if (idx < 6'd62) begin
      b64_char = wide - 8'd4;
    end else if (idx == 6'd62) begin
      b64_char = 8'd43;
    end else begin
      b64_char = 8'd47;
    end
  endfunction

endpackage

### rtl/core/b64lw_front.sv
// ---------------------------------------------------------------------------
// Base64 line-wrapped encoder front end
// Takes input beats, groups bytes and decides line breaks; emits one job
// per byte that causes output.
// ---------------------------------------------------------------------------
module b64lw_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  input  logic [7:0]     s_axis_tdata_i,
  input  logic           s_axis_tlast_i,
  input  logic [7:0]     blocks_per_line_i,
  output logic           push_o,
  output b64lw_pkg::job_t job_o,
  input  logic           full_i
);
  import b64lw_pkg::*;

  logic [15:0] held_q, held_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [7:0]  blocks_q, blocks_d;
  logic        start_q, start_d;
  logic        accept;
  logic        group_full;
  logic [7:0]  blocks_after;
  job_t        job;

  assign s_axis_tready_o = !full_i;
  assign accept          = s_axis_tvalid_i && !full_i;
  assign group_full      = (cnt_q == 2'd2);
  assign blocks_after    = blocks_q + {7'd0, group_full || s_axis_tlast_i};

  always_comb begin
    job           = '0;
    job.lead_nl   = start_q;
    job.has_block = group_full || s_axis_tlast_i;
    held_d        = held_q;
    cnt_d         = cnt_q;
    blocks_d      = blocks_q;
    start_d       = start_q;

    if (group_full) begin
      job.b0 = held_q[15:8];
      job.b1 = held_q[7:0];
      job.b2 = s_axis_tdata_i;
      held_d = '0;
      cnt_d  = '0;
    end else if (s_axis_tlast_i) begin
      job.pad4 = 1'b1;
      if (cnt_q == 2'd0) begin
        job.b0   = s_axis_tdata_i;
        job.pad3 = 1'b1;
      end else begin
        job.b0 = held_q[15:8];
        job.b1 = s_axis_tdata_i;
      end
      held_d = '0;
      cnt_d  = '0;
    end else begin
      if (cnt_q == 2'd0) begin
        held_d = {s_axis_tdata_i, 8'd0};
      end else begin
        held_d = {held_q[15:8], s_axis_tdata_i};
      end
      cnt_d = cnt_q + 2'd1;
    end

    if (s_axis_tlast_i) begin
      job.tail_nl   = 1'b1;
      job.tail_done = 1'b1;
      blocks_d      = '0;
      start_d       = 1'b1;
    end else begin
      start_d = 1'b0;
      if (blocks_after != 8'd0 && blocks_after >= blocks_per_line_i) begin
        job.tail_nl = 1'b1;
        blocks_d    = '0;
      end else begin
        blocks_d = blocks_after;
      end
    end
  end

  assign job_o  = job;
  assign push_o = accept && (job_mask(job) != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= '0;
      cnt_q    <= '0;
      blocks_q <= '0;
      start_q  <= 1'b1;
    end else if (accept) begin
      held_q   <= held_d;
      cnt_q    <= cnt_d;
      blocks_q <= blocks_d;
      start_q  <= start_d;
    end
  end

endmodule

### rtl/core/b64lw_queue.sv
// ---------------------------------------------------------------------------
// Base64 line-wrapped encoder job queue
// Small first-in first-out buffer between the front end and the emitter.
// ---------------------------------------------------------------------------
module b64lw_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b64lw_pkg::job_t push_job_i,
  output logic            full_o,
  output logic            pop_valid_o,
  output b64lw_pkg::job_t pop_job_o,
  input  logic            pop_i
);
  import b64lw_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o      = (cnt_q == FullCnt);
  assign pop_valid_o = (cnt_q != '0);
  assign pop_job_o   = mem_q[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

### rtl/core/b64lw_emit.sv
// ---------------------------------------------------------------------------
// Base64 line-wrapped encoder emitter
// Walks the slots of each job and drives one character per beat through a
// registered output stage.
// ---------------------------------------------------------------------------
module b64lw_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  b64lw_pkg::job_t job_i,
  output logic            pop_o,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,
  output logic            m_axis_tlast_o,
  output logic            m_axis_tuser_o
);
  import b64lw_pkg::*;

  job_t       job_q, act_job;
  slot_mask_t mask_q, act_mask, low, rest;
  logic       out_valid_q, last_q, done_q;
  logic [7:0] char_q, char_d;
  logic       load, emit, use_new;

  // A job still in progress takes precedence over the queue head.
  assign use_new  = (mask_q == '0);
  assign act_job  = use_new ? job_i : job_q;
  assign act_mask = use_new ? (job_valid_i ? job_mask(job_i) : '0) : mask_q;
  assign low      = act_mask & (~act_mask + slot_mask_t'(1));
  assign rest     = act_mask & ~low;

  assign load  = !out_valid_q || m_axis_tready_i;
  assign emit  = load && (act_mask != '0);
  assign pop_o = emit && use_new;

  always_comb begin
    if (low[1]) begin
      char_d = b64_char(act_job.b0[7:2]);
    end else if (low[2]) begin
      char_d = b64_char({act_job.b0[1:0], act_job.b1[7:4]});
    end else if (low[3]) begin
      char_d = act_job.pad3 ? CharPad : b64_char({act_job.b1[3:0], act_job.b2[7:6]});
    end else if (low[4]) begin
      char_d = act_job.pad4 ? CharPad : b64_char(act_job.b2[5:0]);
    end else begin
      char_d = CharNl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      job_q  <= act_job;
      char_q <= char_d;
      last_q <= (rest == '0);
      done_q <= low[NumSlots-1] && act_job.tail_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        mask_q      <= rest;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = char_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tuser_o  = done_q;

endmodule

### rtl/core/base64_line_wrapped_encoder_top.sv
// With the emitter idle, a byte's first character passes through a queue entry and then the
// output register before it is valid on the master side.
// Throughput: one input beat per cycle while the job queue has room and one output beat
// per cycle while the master side is ready; a byte causes 0 to 6 characters (about 1.4).
// Reset: rst_ni is asynchronous, active low; it empties the queue, drops any partial
// group and line count, and restores blocks_per_line to 20.
// ---------------------------------------------------------------------------
// Base64 line-wrapped encoder
// Streaming base64 encoder with newline framing and configurable line length.
// ---------------------------------------------------------------------------
`include "base64_line_wrapped_encoder_top_defines.svh"

module base64_line_wrapped_encoder_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration: blocks_per_line, written whenever cfg_we_i is high.
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  // Slave side.
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // last_byte
  // Master side.
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_char
  output logic       m_axis_tlast_o,   // last_of_run
  output logic       m_axis_tuser_o    // [0] message_done
);
  import b64lw_pkg::*;

  // The front end does all bookkeeping at the moment a beat is accepted:
  // it tracks the open group of up to two held bytes, counts blocks on the
  // current line against blocks_per_line, and remembers whether the next
  // byte opens a message. Everything one byte causes is summarized as a
  // job (leading newline, a block with its pad marks, trailing newline).
  // Bytes that cause nothing produce no job.
  //
  // Jobs sit in a short queue, so input keeps flowing while the emitter
  // works through longer jobs or the master side stalls.
  //
  // The emitter turns each job into one to six characters, one per beat,
  // through a registered output stage. It moves straight from the last
  // slot of one job to the first slot of the next, without a gap.

  logic [7:0] blocks_per_line_q;
  logic       push, full, pop, job_valid;
  job_t       push_job, pop_job;
  logic       out_done, out_pad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_per_line_q <= 8'd20;
    end else if (cfg_we_i) begin
      blocks_per_line_q <= cfg_wdata_i;
    end
  end

  b64lw_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s_axis_tvalid_i   (s_axis_tvalid_i),
    .s_axis_tready_o   (s_axis_tready_o),
    .s_axis_tdata_i    (s_axis_tdata_i),
    .s_axis_tlast_i    (s_axis_tlast_i),
    .blocks_per_line_i (blocks_per_line_q),
    .push_o            (push),
    .job_o             (push_job),
    .full_i            (full)
  );

  b64lw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_job_i  (push_job),
    .full_o      (full),
    .pop_valid_o (job_valid),
    .pop_job_o   (pop_job),
    .pop_i       (pop)
  );

  b64lw_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_i           (pop_job),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Shorthands for the checks below: a valid beat carrying the message end
  // marker, and a valid beat carrying a padding character.
  assign out_done = m_axis_tvalid_o && m_axis_tuser_o;
  assign out_pad  = m_axis_tvalid_o && (m_axis_tdata_o == CharPad);

  // The closing newline of a message is always the final character of its byte.
  `B64LW_ASSERT_NOW(a_done_is_last, out_done, m_axis_tlast_o, "message end without last")
  // The message end marker only rides on a newline.
  `B64LW_ASSERT_NOW(a_done_is_nl, out_done, m_axis_tdata_o == CharNl, "done on non-newline")
  // Padding is always followed by the closing newline of the same byte.
  `B64LW_ASSERT_NOW(a_pad_not_last, out_pad, !m_axis_tlast_o, "padding ends a run")
  // A job pop always fills the output stage in the next cycle.
  `B64LW_ASSERT_NEXT(a_pop_fills_out, pop, m_axis_tvalid_o, "popped job produced no beat")

endmodule

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// Base64 line-wrapped encoder testbench
// Drives raw message bytes into the encoder, tracks the expected character
// stream with a self-contained bit-exact predictor, and checks every output
// beat field by field, under random gaps and stalls on both stream sides.
// ---------------------------------------------------------------------------
module tb_top;

  import b64lw_pkg::*;

  // Clock period is 20 units; the run is aborted if it goes on far longer
  // than the slowest legal schedule (every beat stalled the longest time).
  localparam int unsigned CycleLimit     = 500000;
  // Random bytes after the directed rows; together they make about 420.
  localparam int unsigned RandomBytes    = 394;
  localparam int unsigned DrainCycles    = 20;
  // A byte's first character comes out only after its beat has passed the job queue and
  // the output register; wait a good deal more before touching the line-length register.
  localparam int unsigned SettleCycles   = 8;
  localparam int          NumDirected    = 26;

  localparam logic [8*64-1:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // One output beat as the scoreboard sees it.
  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
    logic       message_done;
  } char_beat_t;

  // One row of the directed stimulus table. When typed is set, the expected
  // characters are given directly in typed_chars (first character in the
  // highest used byte) and the predictor output is not used for that row.
  typedef struct packed {
    logic        do_cfg;
    logic [7:0]  cfg_val;
    logic [7:0]  data_byte;
    logic        is_last;
    logic        typed;
    logic [2:0]  typed_n;
    logic [47:0] typed_chars;
  } stim_row_t;

  // DUT-facing signals; the inputs are all driven to known values from time zero.
  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       cfg_we_i        = 1'b0;
  logic [7:0] cfg_wdata_i     = 8'd0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i  = 8'd0;
  logic       s_axis_tlast_i  = 1'b0;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b1;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tlast_o;
  logic       m_axis_tuser_o;

  // Side information that travels with the beat currently on the slave side.
  logic        beat_typed       = 1'b0;
  logic [2:0]  beat_typed_n     = 3'd0;
  logic [47:0] beat_typed_chars = 48'd0;

  // Predictor state: a private copy of the encoder's register and state.
  logic [7:0] wrap_blocks  = 8'd20;
  logic [7:0] held_first   = 8'd0;
  logic [7:0] held_second  = 8'd0;
  logic [1:0] group_fill   = 2'd0;
  logic [7:0] line_blocks  = 8'd0;
  logic       at_msg_start = 1'b1;

  // Characters produced by the most recent prediction.
  logic [7:0] pred_chars [6];
  int         pred_n;

  char_beat_t pending_chars [$];
  int         error_count  = 0;
  int         cycle_count  = 0;
  int         bytes_sent   = 0;
  int         sink_stall   = 0;
  int         sink_calm    = 0;
  int         source_calm  = 0;

  // Directed table. The first rows start from reset with 20 blocks per line,
  // so their output can be read straight off the encoding rules: single and
  // double byte padding, all-ones and all-zeros groups, and a byte that is
  // only held and shows nothing. Then a one-block line where the closing
  // newline doubles as the wrap, a zero line length that must act like one,
  // the widest line length, and a line length lowered in the middle of a
  // line so the wrap comes with the very next byte, even one that is only held.
  stim_row_t directed_rows [NumDirected] = '{
    '{1'b0, 8'd0,   8'h00, 1'b1, 1'b1, 3'd6, "\nAA==\n"},
    '{1'b0, 8'd0,   8'hff, 1'b1, 1'b1, 3'd6, "\n/w==\n"},
    '{1'b0, 8'd0,   8'hff, 1'b0, 1'b1, 3'd1, "\n"},
    '{1'b0, 8'd0,   8'hff, 1'b0, 1'b1, 3'd0, 48'd0},
    '{1'b0, 8'd0,   8'hff, 1'b1, 1'b1, 3'd5, "////\n"},
    '{1'b0, 8'd0,   8'h00, 1'b0, 1'b1, 3'd1, "\n"},
    '{1'b0, 8'd0,   8'hff, 1'b1, 1'b1, 3'd5, "AP8=\n"},
    '{1'b1, 8'd1,   8'h00, 1'b0, 1'b1, 3'd1, "\n"},
    '{1'b0, 8'd0,   8'h00, 1'b0, 1'b1, 3'd0, 48'd0},
    '{1'b0, 8'd0,   8'h00, 1'b1, 1'b1, 3'd5, "AAAA\n"},
    '{1'b1, 8'd0,   8'h12, 1'b0, 1'b0, 3'd0, 48'd0},
    '{1'b0, 8'd0,   8'h34, 1'b0, 1'b0, 3'd0, 48'd0},
    '{1'b0, 8'd0,   8'h56, 1'b0, 1'b0, 3'd0, 48'd0},
    '{1'b0, 8'd0,   8'hab, 1'b0, 1'b0, 3'd0, 48'd0},
    '{1'b0, 8'd0,   8'hcd, 1'b0, 1'b0, 3'd0, 48'd0},
    '{1'b0, 8'd0,   8'hef, 1'b1, 1'b0, 3'd0, 48'd0},
    '{1'b1, 8'd255, 8'h80, 1'b0, 1'b0, 3'd0, 48'd0},
    '{1'b0, 8'd0,   8'h01, 1'b0, 1'b0, 3'd0, 48'd0},
    '{1'b0, 8'd0,   8'h7f, 1'b0, 1'b0, 3'd0, 48'd0},
    '{1'b0, 8'd0,   8'h55, 1'b0, 1'b0, 3'd0, 48'd0},
    '{1'b0, 8'd0,   8'haa, 1'b0, 1'b0, 3'd0, 48'd0},
    '{1'b0, 8'd0,   8'h0f, 1'b0, 1'b0, 3'd0, 48'd0},
    '{1'b1, 8'd1,   8'hf0, 1'b0, 1'b0, 3'd0, 48'd0},
    '{1'b0, 8'd0,   8'h3c, 1'b0, 1'b0, 3'd0, 48'd0},
    '{1'b0, 8'd0,   8'hc3, 1'b0, 1'b0, 3'd0, 48'd0},
    '{1'b0, 8'd0,   8'h99, 1'b1, 1'b0, 3'd0, 48'd0}
  };

  base64_line_wrapped_encoder_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic logic [7:0] alphabet_char(input logic [5:0] idx);
    alphabet_char = Alphabet[8*(63-idx) +: 8];
  endfunction

  task automatic push_char(input logic [7:0] ch);
    pred_chars[pred_n] = ch;
    pred_n++;
  endtask

  // Encodes one group of up to three bytes; missing bytes become padding.
  task automatic push_group(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input int fill);
    push_char(alphabet_char(b0[7:2]));
    push_char(alphabet_char({b0[1:0], b1[7:4]}));
    push_char(fill > 1 ? alphabet_char({b1[3:0], b2[7:6]}) : CharPad);
    push_char(fill > 2 ? alphabet_char(b2[5:0]) : CharPad);
    line_blocks = line_blocks + 8'd1;
  endtask

  // Works out the characters one accepted byte causes and advances state.
  task automatic encode_byte(input logic [7:0] data_byte, input logic is_last);
    int fill;
    pred_n = 0;
    if (at_msg_start) begin
      push_char(CharNl);
      at_msg_start = 1'b0;
    end
    fill = int'(group_fill) + 1;
    if (fill >= 3) begin
      push_group(held_first, held_second, data_byte, 3);
      group_fill = 2'd0;
    end else if (is_last) begin
      if (fill == 1) begin
        push_group(data_byte, 8'd0, 8'd0, 1);
      end else begin
        push_group(held_first, data_byte, 8'd0, 2);
      end
      group_fill = 2'd0;
    end else begin
      if (fill == 1) begin
        held_first  = data_byte;
        held_second = 8'd0;
      end else begin
        held_second = data_byte;
      end
      group_fill = fill[1:0];
    end
    // The closing newline also serves as the wrap when the line is full.
    if (is_last) begin
      push_char(CharNl);
      line_blocks  = 8'd0;
      group_fill   = 2'd0;
      at_msg_start = 1'b1;
    end else if (line_blocks != 8'd0 && line_blocks >= wrap_blocks) begin
      push_char(CharNl);
      line_blocks = 8'd0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Scoreboard: slave-side beats are turned into expectations first, then
  // the master-side beat of the same edge is checked against the oldest
  // expectation. Both run in one process, so the order is fixed.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    char_beat_t want;
    int         n;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        encode_byte(s_axis_tdata_i, s_axis_tlast_i);
        n = beat_typed ? int'(beat_typed_n) : pred_n;
        for (int k = 0; k < n; k++) begin
          want.out_char     = beat_typed ? beat_typed_chars[8*(n-1-k) +: 8] : pred_chars[k];
          want.last_of_run  = (k == n - 1);
          want.message_done = s_axis_tlast_i && (k == n - 1);
          pending_chars.push_back(want);
        end
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_chars.size() == 0) begin
          $error("unexpected output beat: out_char %0d", m_axis_tdata_o);
          error_count++;
        end else begin
          want = pending_chars.pop_front();
          if (m_axis_tdata_o !== want.out_char) begin
            $error("out_char: expected %0d, actual %0d", want.out_char, m_axis_tdata_o);
            error_count++;
          end
          if (m_axis_tlast_o !== want.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d", want.last_of_run,
                   m_axis_tlast_o);
            error_count++;
          end
          if (m_axis_tuser_o !== want.message_done) begin
            $error("message_done: expected %0d, actual %0d", want.message_done,
                   m_axis_tuser_o);
            error_count++;
          end
        end
      end
    end
  end

  // Hard stop in case the encoder hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, mostly short, some long, and now and then a
  // calm stretch where the receiver is always ready.
  always @(negedge clk_i) begin
    int r;
    if (sink_stall > 0) begin
      m_axis_tready_i <= 1'b0;
      sink_stall--;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (sink_calm > 0) begin
        sink_calm--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          sink_calm = $urandom_range(20, 120);
        end else if (r < 28) begin
          sink_stall = $urandom_range(1, 3);
        end else if (r < 31) begin
          sink_stall = $urandom_range(8, 30);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  function automatic int pick_source_gap();
    int r;
    if (source_calm > 0) begin
      source_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      source_calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Presents one byte at the falling edge and holds it until accepted. The
  // valid line stays high across back-to-back beats.
  task automatic send_byte(input logic [7:0] data_byte, input logic is_last,
                           input logic typed, input logic [2:0] typed_n,
                           input logic [47:0] typed_chars);
    int gap;
    gap = pick_source_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i  <= 1'b1;
    s_axis_tdata_i   <= data_byte;
    s_axis_tlast_i   <= is_last;
    beat_typed       <= typed;
    beat_typed_n     <= typed_n;
    beat_typed_chars <= typed_chars;
    do @(posedge clk_i); while (!s_axis_tready_o);
    bytes_sent++;
  endtask

  // Pauses the sender until every expected character has come out, lets
  // the encoder settle (a held byte shows no output), then writes the
  // line length. The predictor copy is updated at the same moment.
  task automatic set_line_length(input logic [7:0] value);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    wrap_blocks  = value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Line lengths for the random phases lean on short lines so wraps are
  // frequent, with the extremes and the reset value mixed in.
  function automatic logic [7:0] pick_line_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'd1;
    if (r < 55) return 8'($urandom_range(2, 6));
    if (r < 65) return 8'd255;
    if (r < 80) return 8'd20;
    return 8'($urandom_range(1, 255));
  endfunction

  // Most messages are short; a few are long enough to span several lines.
  function automatic int pick_message_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 9);
    if (r < 95) return $urandom_range(10, 70);
    return $urandom_range(71, 160);
  endfunction

  initial begin : stimulus
    int msg_len;
    int msgs_in_phase;
    int retune_at;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumDirected; i++) begin
      if (directed_rows[i].do_cfg) begin
        set_line_length(directed_rows[i].cfg_val);
      end
      send_byte(directed_rows[i].data_byte, directed_rows[i].is_last,
                directed_rows[i].typed, directed_rows[i].typed_n,
                directed_rows[i].typed_chars);
    end

    // Random phases: each picks a line length and sends a few messages of
    // random content. Some longer messages get their line length changed
    // partway through, while the sender waits for the output to drain.
    // The last message is cut short so the byte budget is met exactly.
    bytes_sent = 0;
    while (bytes_sent < int'(RandomBytes)) begin
      set_line_length(pick_line_length());
      msgs_in_phase = $urandom_range(1, 4);
      for (int m = 0; m < msgs_in_phase && bytes_sent < int'(RandomBytes); m++) begin
        msg_len = pick_message_length();
        if (msg_len > int'(RandomBytes) - bytes_sent) begin
          msg_len = int'(RandomBytes) - bytes_sent;
        end
        retune_at = (msg_len > 6 && $urandom_range(0, 9) == 0) ?
                    $urandom_range(1, msg_len - 1) : -1;
        for (int j = 0; j < msg_len; j++) begin
          if (j == retune_at) begin
            set_line_length(pick_line_length());
          end
          send_byte(8'($urandom_range(0, 255)), j == msg_len - 1, 1'b0, 3'd0, 48'd0);
        end
      end
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    // Any stray beat after the last expectation shows up as unexpected.
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
